### design/tbmt_pkg.sv
package tbmt_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int VAL_W       = 16;
  localparam int CH_W        = 4;

  localparam int          APB_ADDR_W    = 3;
  localparam logic [0:0]  REG_INTERVAL  = 1'b0;
  localparam logic [0:0]  REG_THRESHOLD = 1'b1;
  localparam logic [15:0] INTERVAL_RST  = 16'd255;
  localparam logic [15:0] THRESHOLD_RST = 16'd0;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic commit;
    logic clear;
    logic scan_acc;
    logic scan_first;
    logic sort_first;
    logic sort_step;
    logic sort_last;
    logic mid_lo;
    logic mid_hi;
    logic emit;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic ch_ok;
    logic hit;
    logic spread_ok;
    logic out_free;
  } sts_t;

endpackage

### design/tbmt_ram.sv
module tbmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 320
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/tbmt_ctrl.sv
module tbmt_ctrl
  import tbmt_pkg::*;
#(
  parameter int CHANNELS     = 16,
  parameter int BUFFER_DEPTH = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sts_t                              sts,
  output cmd_t                              cmd,
  output logic [$clog2(BUFFER_DEPTH)-1:0]   rd_idx,
  output logic [$clog2(BUFFER_DEPTH)-1:0]   wr_idx,
  output logic [$clog2(CHANNELS*BUFFER_DEPTH)-1:0] clr_addr
);

  localparam int ENTRIES = CHANNELS * BUFFER_DEPTH;
  localparam int AW      = $clog2(ENTRIES);
  localparam int IW      = $clog2(BUFFER_DEPTH);
  localparam int CNT_MAX = (ENTRIES > BUFFER_DEPTH + 2) ? ENTRIES : BUFFER_DEPTH + 2;
  localparam int CW      = $clog2(CNT_MAX + 1);
  localparam int MID_LOW  = BUFFER_DEPTH / 2 - 1;
  localparam int MID_HIGH = BUFFER_DEPTH / 2;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_WRITE  = 8'b0000_0100,
    ST_SCAN   = 8'b0000_1000,
    ST_DECIDE = 8'b0001_0000,
    ST_SORT   = 8'b0010_0000,
    ST_MID    = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   cnt, cnt_next;
  logic [IW-1:0]   pass, pass_next;
  logic [CW-1:0]   cnt_m2;

  assign cnt_m2   = cnt - CW'(2);
  assign wr_idx   = cnt_m2[IW-1:0];
  assign clr_addr = cnt[AW-1:0];

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pass_next  = pass;
    cmd        = '0;
    in_ready   = 1'b0;
    rd_idx     = cnt[IW-1:0];
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        cnt_next  = cnt + CW'(1);
        if (cnt == CW'(ENTRIES - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cnt_next = '0;
        if (!sts.ch_ok) begin
          state_next = ST_OUT;
        end else begin
          cmd.commit = 1'b1;
          state_next = sts.hit ? ST_SCAN : ST_OUT;
        end
      end
      ST_SCAN: begin
        // read data arrives in the cycle after its address
        cmd.scan_acc   = (cnt != '0);
        cmd.scan_first = (cnt == CW'(1));
        cnt_next       = cnt + CW'(1);
        if (cnt == CW'(BUFFER_DEPTH)) begin
          cnt_next   = '0;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cnt_next  = '0;
        pass_next = '0;
        state_next = sts.spread_ok ? ST_SORT : ST_OUT;
      end
      ST_SORT: begin
        // one bubble pass: carry the running max up, write the smaller back
        cmd.sort_first = (cnt == CW'(1));
        cmd.sort_step  = (cnt >= CW'(2)) && (cnt <= CW'(BUFFER_DEPTH));
        cmd.sort_last  = (cnt == CW'(BUFFER_DEPTH + 1));
        cnt_next       = cnt + CW'(1);
        if (cmd.sort_last) begin
          cnt_next = '0;
          if (pass == IW'(BUFFER_DEPTH - 2)) begin
            state_next = ST_MID;
          end else begin
            pass_next = pass + IW'(1);
          end
        end
      end
      ST_MID: begin
        rd_idx     = (cnt == '0) ? IW'(MID_LOW) : IW'(MID_HIGH);
        cmd.mid_lo = (cnt == CW'(1));
        cmd.mid_hi = (cnt == CW'(2));
        cnt_next   = cnt + CW'(1);
        if (cmd.mid_hi) begin
          cnt_next   = '0;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd.emit = sts.out_free;
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      pass  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pass  <= pass_next;
    end
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result emitted while output register full");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_WRITE)
    else $error("item accepted without entering write");

endmodule

### design/tbmt_dp.sv
module tbmt_dp
  import tbmt_pkg::*;
#(
  parameter int CHANNELS     = 16,
  parameter int BUFFER_DEPTH = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cmd_t                              cmd,
  output sts_t                              sts,
  input  logic [$clog2(BUFFER_DEPTH)-1:0]   rd_idx,
  input  logic [$clog2(BUFFER_DEPTH)-1:0]   wr_idx,
  input  logic [$clog2(CHANNELS*BUFFER_DEPTH)-1:0] clr_addr,
  input  logic [IN_TDATA_W-1:0]             in_data,
  input  logic [15:0]                       recal_interval,
  input  logic [15:0]                       calibration_threshold,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [OUT_TDATA_W-1:0]            out_data
);

  localparam int ENTRIES = CHANNELS * BUFFER_DEPTH;
  localparam int AW      = $clog2(ENTRIES);
  localparam int IW      = $clog2(BUFFER_DEPTH);
  localparam int CHW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CH_W-1:0]  ch;
  logic [VAL_W-1:0] sample;
  logic [AW-1:0]    base;
  logic [CHW-1:0]   ch_idx;
  logic             checked, updated;

  logic [IW-1:0]    wpos     [CHANNELS];
  logic [15:0]      scan_cnt [CHANNELS];
  logic [15:0]      baseline [CHANNELS];

  logic [VAL_W-1:0] mx, mn, carry, lo;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;
  logic [IW-1:0]    widx;
  logic [16:0]      mid_sum;
  logic [15:0]      base_out;

  assign ch_idx = ch[CHW-1:0];

  assign sts.ch_ok     = ({1'b0, ch} < 5'(CHANNELS));
  assign sts.hit       = scan_cnt[ch_idx] >= recal_interval;
  assign sts.spread_ok = (mx != '0) && ((mx - mn) < calibration_threshold);
  assign sts.out_free  = !out_valid || out_ready;

  assign widx      = cmd.commit ? wpos[ch_idx] : wr_idx;
  assign ram_we    = cmd.clear | cmd.commit | cmd.sort_step | cmd.sort_last;
  assign ram_waddr = cmd.clear ? clr_addr : base + AW'(widx);
  assign ram_raddr = base + AW'(rd_idx);

  always_comb begin
    ram_wdata = '0;
    if (cmd.commit) begin
      ram_wdata = sample;
    end else if (cmd.sort_step) begin
      ram_wdata = (ram_rdata < carry) ? ram_rdata : carry;
    end else if (cmd.sort_last) begin
      ram_wdata = carry;
    end
  end

  assign mid_sum  = 17'(lo) + 17'(ram_rdata);
  assign base_out = sts.ch_ok ? baseline[ch_idx] : 16'd0;

  tbmt_ram #(
    .WIDTH (VAL_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // item payload and window scratch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch     <= in_data[CH_W-1:0];
      sample <= in_data[CH_W+VAL_W-1:CH_W];
      base   <= AW'(32'(in_data[CH_W-1:0]) * BUFFER_DEPTH);
    end
    if (cmd.scan_acc) begin
      if (cmd.scan_first || ram_rdata > mx) begin
        mx <= ram_rdata;
      end
      if (cmd.scan_first || ram_rdata < mn) begin
        mn <= ram_rdata;
      end
    end
    if (cmd.sort_first) begin
      carry <= ram_rdata;
    end else if (cmd.sort_step && ram_rdata >= carry) begin
      carry <= ram_rdata;
    end
    if (cmd.mid_lo) begin
      lo <= ram_rdata;
    end
    if (cmd.emit) begin
      out_data <= {2'b00, updated, checked, base_out, ch};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wpos[i]     <= '0;
        scan_cnt[i] <= '0;
        baseline[i] <= '0;
      end
      checked   <= 1'b0;
      updated   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        checked <= 1'b0;
        updated <= 1'b0;
      end
      if (cmd.commit) begin
        wpos[ch_idx] <= (wpos[ch_idx] == IW'(BUFFER_DEPTH - 1)) ? '0 : wpos[ch_idx] + IW'(1);
        if (sts.hit) begin
          scan_cnt[ch_idx] <= '0;
          checked          <= 1'b1;
        end else begin
          scan_cnt[ch_idx] <= scan_cnt[ch_idx] + 16'd1;
        end
      end
      if (cmd.mid_hi) begin
        baseline[ch_idx] <= mid_sum[16:1];
        updated          <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_sort_order: assert property (@(posedge clk) disable iff (rst)
    cmd.sort_step |-> ram_wdata <= carry)
    else $error("bubble pass wrote a value above the carried max");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.scan_acc) && !cmd.scan_acc |-> mn <= mx)
    else $error("window min above max after scan");

  a_update_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data[21] |-> out_data[20])
    else $error("baseline updated without a window check");

endmodule

### design/touch_baseline_median_tracker.sv
// Result path: when the window check is skipped the result is emitted directly; when the check
// fails it follows a scan of the window; when it passes, the window is sorted by D-1 bubble
// passes (D = buffer depth) over the one memory before the middle entries are averaged.
// Throughput: one item at a time; the next item is accepted in the cycle after the result is
// loaded into the output register, and a held result blocks the load.
// Reset: synchronous, active high; a clear pass over all CHANNELS*BUFFER_DEPTH entries zeroes the memory first.
module touch_baseline_median_tracker
  import tbmt_pkg::*;
#(
  parameter int CHANNELS     = 16,
  parameter int BUFFER_DEPTH = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // channel[3:0], raw_count[19:4]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // channel_out[3:0], baseline_value[19:4],
                                            // window_checked[20], baseline_updated[21]
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int AW = $clog2(CHANNELS * BUFFER_DEPTH);
  localparam int IW = $clog2(BUFFER_DEPTH);

  logic [15:0]   recal_interval, calibration_threshold;
  cmd_t          cmd;
  sts_t          sts;
  logic [IW-1:0] rd_idx, wr_idx;
  logic [AW-1:0] clr_addr;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? {16'd0, calibration_threshold}
                                              : {16'd0, recal_interval};

  always_ff @(posedge clk) begin
    if (rst) begin
      recal_interval        <= INTERVAL_RST;
      calibration_threshold <= THRESHOLD_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_INTERVAL:  recal_interval        <= pwdata[15:0];
        REG_THRESHOLD: calibration_threshold <= pwdata[15:0];
        default:       ;
      endcase
    end
  end

  tbmt_ctrl #(
    .CHANNELS     (CHANNELS),
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd),
    .rd_idx   (rd_idx),
    .wr_idx   (wr_idx),
    .clr_addr (clr_addr)
  );

  tbmt_dp #(
    .CHANNELS     (CHANNELS),
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .sts                   (sts),
    .rd_idx                (rd_idx),
    .wr_idx                (wr_idx),
    .clr_addr              (clr_addr),
    .in_data               (s_tdata),
    .recal_interval        (recal_interval),
    .calibration_threshold (calibration_threshold),
    .out_valid             (m_tvalid),
    .out_ready             (m_tready),
    .out_data              (m_tdata)
  );

endmodule

### test/touch_baseline_median_tracker_test.sv
`timescale 1ns / 100ps

module touch_baseline_median_tracker_test
  import tbmt_pkg::*;
;

  localparam int NUM_CH      = 16;
  localparam int WIN_DEPTH   = 20;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int LONG_HOLD   = 3000;

  typedef struct packed {
    logic [3:0]  ch;
    logic [15:0] base;
    logic        checked;
    logic        updated;
  } baseline_res_t;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_SET_INTERVAL, ROW_SET_THRESHOLD} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [3:0]  ch;
    logic [15:0] val;
    bit          typed;
    logic [15:0] base;
    logic        checked;
    logic        updated;
  } row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // channel[3:0], raw_count[19:4]
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // channel_out[3:0], baseline_value[19:4],
                                     // window_checked[20], baseline_updated[21]
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  // predictor state
  logic [15:0] win_buf [NUM_CH][WIN_DEPTH];
  logic [4:0]  win_pos [NUM_CH];
  logic [15:0] scan_cnt [NUM_CH];
  logic [15:0] ch_base [NUM_CH];
  logic [15:0] cur_interval;
  logic [15:0] cur_threshold;

  baseline_res_t expected_q[$];
  int  mismatches;
  int  n_items;
  int  n_results;
  int  n_checked;
  int  n_updated;
  int  cycles;
  bit  hold_req;

  row_t dir_rows[$];

  touch_baseline_median_tracker u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic baseline_res_t track_sample(logic [3:0] ch, logic [15:0] raw);
    baseline_res_t r;
    int pos;
    logic [15:0] mx, mn, v;
    int m;
    r = '0;
    r.ch = ch;
    pos = win_pos[ch];
    if (pos >= WIN_DEPTH) pos = 0;
    win_buf[ch][pos] = raw;
    if (scan_cnt[ch] >= cur_interval) begin
      scan_cnt[ch] = '0;
      r.checked = 1'b1;
      mx = win_buf[ch][0];
      mn = win_buf[ch][0];
      for (int k = 1; k < WIN_DEPTH; k++) begin
        if (win_buf[ch][k] > mx) mx = win_buf[ch][k];
        if (win_buf[ch][k] < mn) mn = win_buf[ch][k];
      end
      if (mx != 0 && (mx - mn) < cur_threshold) begin
        // sort ascending in place; the order stays for later samples
        for (int k = 1; k < WIN_DEPTH; k++) begin
          v = win_buf[ch][k];
          m = k;
          while (m > 0 && win_buf[ch][m-1] > v) begin
            win_buf[ch][m] = win_buf[ch][m-1];
            m--;
          end
          win_buf[ch][m] = v;
        end
        ch_base[ch] = 16'((17'(win_buf[ch][WIN_DEPTH/2-1]) +
                           17'(win_buf[ch][WIN_DEPTH/2])) >> 1);
        r.updated = 1'b1;
      end
    end else begin
      scan_cnt[ch] = scan_cnt[ch] + 16'd1;
    end
    pos++;
    if (pos >= WIN_DEPTH) pos = 0;
    win_pos[ch] = 5'(pos);
    r.base = ch_base[ch];
    return r;
  endfunction

  task automatic send_sample(logic [3:0] ch, logic [15:0] raw, bit typed,
                             baseline_res_t typed_res);
    int gap;
    baseline_res_t r;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, raw, ch};
    do @(posedge clk); while (!s_tready);
    r = track_sample(ch, raw);
    expected_q.push_back(typed ? typed_res : r);
    n_items++;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_INTERVAL) cur_interval = value;
    else cur_threshold = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic row_t mk_row(row_kind_t kind, logic [3:0] ch, logic [15:0] val,
                                  bit typed = 0, logic [15:0] base = 0,
                                  logic checked = 0, logic updated = 0);
    row_t r;
    r.kind = kind; r.ch = ch; r.val = val; r.typed = typed;
    r.base = base; r.checked = checked; r.updated = updated;
    return r;
  endfunction

  // receiver: random stall per item, with one long hold-off on request
  initial begin
    int n;
    baseline_res_t got, want;
    m_tready <= 1'b0;
    forever begin
      n = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (hold_req) begin
        hold_req = 1'b0;
        n = LONG_HOLD;
      end
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.ch      = m_tdata[3:0];
      got.base    = m_tdata[19:4];
      got.checked = m_tdata[20];
      got.updated = m_tdata[21];
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result ch=%0d base=%0d chk=%0b upd=%0b", $time,
                 got.ch, got.base, got.checked, got.updated);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (got.checked) n_checked++;
        if (got.updated) n_updated++;
        if (got !== want) begin
          $display("%0t: ch expected %0d got %0d, base expected %0d got %0d,", $time,
                   want.ch, got.ch, want.base, got.base);
          $display("%0t:   checked expected %0b got %0b, updated expected %0b got %0b",
                   $time, want.checked, got.checked, want.updated, got.updated);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] intervals [8];
    logic [15:0] thresholds [8];
    logic [15:0] lvl [NUM_CH];
    logic [15:0] amp, raw;
    logic [3:0]  ch;
    baseline_res_t tr;
    row_t row;

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    hold_req = 1'b0;
    mismatches = 0; n_items = 0; n_results = 0; n_checked = 0; n_updated = 0;
    for (int c = 0; c < NUM_CH; c++) begin
      for (int k = 0; k < WIN_DEPTH; k++) win_buf[c][k] = '0;
      win_pos[c] = '0; scan_cnt[c] = '0; ch_base[c] = '0;
    end
    cur_interval  = INTERVAL_RST;
    cur_threshold = THRESHOLD_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // after reset nothing is checked yet
    dir_rows.push_back(mk_row(ROW_SAMPLE, 4'd0, 16'h0000, 1, 16'd0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, 4'd15, 16'hFFFF, 1, 16'd0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, 4'd7, 16'h5555, 1, 16'd0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, 4'd8, 16'hAAAA, 1, 16'd0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SET_INTERVAL, 4'd0, 16'd0));
    dir_rows.push_back(mk_row(ROW_SET_THRESHOLD, 4'd0, 16'hFFFF));
    // one sample among zeros: sorted, middle entries are zero
    dir_rows.push_back(mk_row(ROW_SAMPLE, 4'd3, 16'd100, 1, 16'd0, 1, 1));
    // empty window keeps the baseline
    dir_rows.push_back(mk_row(ROW_SAMPLE, 4'd0, 16'h0000, 1, 16'd0, 1, 0));
    // spread equal to the threshold is not below it
    dir_rows.push_back(mk_row(ROW_SAMPLE, 4'd15, 16'hFFFF, 1, 16'd0, 1, 0));
    dir_rows.push_back(mk_row(ROW_SET_THRESHOLD, 4'd0, 16'd0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, 4'd3, 16'd200, 1, 16'd0, 1, 0));
    dir_rows.push_back(mk_row(ROW_SET_THRESHOLD, 4'd0, 16'd1000));
    for (int k = 0; k < 8; k++)
      dir_rows.push_back(mk_row(ROW_SAMPLE, 4'd5, 16'(500 + 10 * k)));
    dir_rows.push_back(mk_row(ROW_SET_INTERVAL, 4'd0, 16'hFFFF));
    dir_rows.push_back(mk_row(ROW_SAMPLE, 4'd9, 16'd1234, 1, 16'd0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, 4'd5, 16'd600));

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      tr.ch = row.ch; tr.base = row.base;
      tr.checked = row.checked; tr.updated = row.updated;
      case (row.kind)
        ROW_SET_INTERVAL: begin
          write_reg(REG_INTERVAL, row.val);
        end
        ROW_SET_THRESHOLD: begin
          write_reg(REG_THRESHOLD, row.val);
        end
        default: begin
          send_sample(row.ch, row.val, row.typed, tr);
        end
      endcase
    end

    intervals  = '{16'd0, 16'd2, 16'd1, 16'd7, 16'd19, 16'd3, 16'd255, 16'hFFFF};
    thresholds = '{16'hFFFF, 16'd5000, 16'd300, 16'd2000, 16'd800, 16'd0, 16'hFFFF, 16'd100};
    tr = '0;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_INTERVAL, intervals[ph]);
      write_reg(REG_THRESHOLD, thresholds[ph]);
      for (int c = 0; c < NUM_CH; c++) lvl[c] = 16'($urandom_range(0, 60000));
      amp = (thresholds[ph] > 16'd2) ? thresholds[ph] / 16'd2 : 16'd50;
      if (amp > 16'd4000) amp = 16'd4000;
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < 143; n++) begin
        // mostly a few channels with samples near their level, so windows fill
        ch = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom);
        if ($urandom_range(0, 9) < 8) raw = lvl[ch] + 16'($urandom_range(0, amp));
        else raw = 16'($urandom);
        send_sample(ch, raw, 0, tr);
      end
    end

    drain();
    repeat (500) @(posedge clk);
    $display("Sent %0d samples over 8 register settings plus a directed set,", n_items);
    $display("received %0d results: %0d window checks, %0d baseline updates",
             n_results, n_checked, n_updated);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### touch_baseline_median_tracker.f
design/tbmt_pkg.sv
design/tbmt_ram.sv
design/tbmt_ctrl.sv
design/tbmt_dp.sv
design/touch_baseline_median_tracker.sv
test/touch_baseline_median_tracker_test.sv
